>>> design/csfl_pkg.sv
package csfl_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FULL_LIGHT_DEF = 255;

    // Register fields and payload fields have fixed widths
    localparam int REG_W   = 9;
    localparam int COORD_W = 11;
    localparam int LEVEL_W = 8;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_FILL  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register index within the configuration port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic load;   // capture the input item
        logic check;  // clip, range check, row base multiply
        logic addr;   // form the first cell address
        logic fill;   // write one run cell, advance
        logic rd;     // read one cell into the result register
        logic sweep;  // write full light, advance
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            fill_ok;
        logic            rd_ok;
        logic            run_last;
        logic            sweep_last;
    } t_dp_stat;

endpackage

>>> design/csfl_ctrl.sv
module csfl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output logic               o_done,
    output csfl_pkg::t_dp_cmd  o_cmd,
    input  csfl_pkg::t_dp_stat i_stat
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_busy = !(r_state == S_IDLE || r_state == S_DONE);
    assign o_done = (r_state == S_DONE);
    assign accept = i_start && !o_busy;

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = accept;
        o_cmd.check = (r_state == S_CHECK);
        o_cmd.addr  = (r_state == S_ADDR);
        o_cmd.fill  = (r_state == S_FILL);
        o_cmd.rd    = (r_state == S_READ);
        o_cmd.sweep = (r_state == S_INIT) || (r_state == S_CLEAR);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE, S_DONE: begin
                n_state = accept ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                case (i_stat.op)
                    csfl_pkg::OP_FILL:  n_state = i_stat.fill_ok ? S_ADDR : S_DONE;
                    csfl_pkg::OP_READ:  n_state = i_stat.rd_ok ? S_ADDR : S_DONE;
                    csfl_pkg::OP_CLEAR: n_state = S_CLEAR;
                    default:            n_state = S_DONE;
                endcase
            end
            S_ADDR: begin
                n_state = (i_stat.op == csfl_pkg::OP_FILL) ? S_FILL : S_READ;
            end
            S_FILL: begin
                if (i_stat.run_last) n_state = S_DONE;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                if (i_stat.sweep_last) n_state = S_DONE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/csfl_dp.sv
module csfl_dp #(
    parameter int MAX_WIDTH  = csfl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csfl_pkg::MAX_HEIGHT_DEF,
    parameter int FULL_LIGHT = csfl_pkg::FULL_LIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  csfl_pkg::t_dp_cmd                   i_cmd,
    output csfl_pkg::t_dp_stat                  o_stat,
    input  logic [csfl_pkg::REG_W-1:0]          i_map_width,
    input  logic [csfl_pkg::REG_W-1:0]          i_map_height,
    input  logic [csfl_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_x_pos,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_y_pos,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_run_length,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_level,
    output logic [csfl_pkg::LEVEL_W-1:0]        o_level_out
);

    localparam int CW    = csfl_pkg::COORD_W;
    localparam int LW    = csfl_pkg::LEVEL_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);
    localparam int MW    = (EW > EH) ? EW : EH;
    localparam int SW    = ((MW > CW) ? MW : CW) + 2;
    localparam int PW    = EW + EH;

    localparam logic [LW-1:0]        FULL_U = LW'(FULL_LIGHT);
    localparam logic signed [CW-1:0] FULL_S = CW'(FULL_LIGHT);

    // captured item
    logic [csfl_pkg::OP_W-1:0] r_op;
    logic signed [CW-1:0]      r_x;
    logic signed [CW-1:0]      r_y;
    logic signed [CW-1:0]      r_run;
    logic signed [CW-1:0]      r_lvl;

    // run setup
    logic [EW-1:0] r_col;
    logic [EW-1:0] r_count;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_addr;
    logic [LW-1:0] r_wlvl;
    logic [LW-1:0] r_result;

    logic [LW-1:0] r_store [DEPTH];

    logic [EW-1:0]        w_eff;
    logic [EH-1:0]        h_eff;
    logic signed [SW-1:0] x_s;
    logic signed [SW-1:0] y_s;
    logic signed [SW-1:0] run_s;
    logic signed [SW-1:0] w_s;
    logic signed [SW-1:0] h_s;
    logic signed [SW-1:0] x_clip_s;
    logic signed [SW-1:0] run_adj_s;
    logic signed [SW-1:0] room_s;
    logic signed [SW-1:0] cnt_s;
    logic                 row_ok;
    logic [PW-1:0]        prod;
    logic [LW-1:0]        lvl_clamp;

    // oversized map registers act as the store limits
    assign w_eff = (32'(i_map_width) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(i_map_width);
    assign h_eff = (32'(i_map_height) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(i_map_height);

    assign x_s   = SW'(r_x);
    assign y_s   = SW'(r_y);
    assign run_s = SW'(r_run);
    assign w_s   = $signed(SW'(w_eff));
    assign h_s   = $signed(SW'(h_eff));

    assign x_clip_s  = (x_s < 0) ? '0 : x_s;
    assign run_adj_s = (x_s < 0) ? run_s + x_s : run_s;
    assign room_s    = w_s - x_clip_s;
    assign cnt_s     = (run_adj_s < room_s) ? run_adj_s : room_s;
    assign row_ok    = (y_s >= 0) && (y_s < h_s);

    assign prod = PW'(EH'(y_s)) * PW'(w_eff);

    assign lvl_clamp = (r_lvl < 0)      ? '0     :
                       (r_lvl > FULL_S) ? FULL_U : LW'(r_lvl);

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.fill_ok    = row_ok && (x_clip_s < w_s) && (run_adj_s > 0);
        o_stat.rd_ok      = row_ok && (x_s >= 0) && (x_s < w_s);
        o_stat.run_last   = (r_count == EW'(1));
        o_stat.sweep_last = (r_addr == AW'(DEPTH - 1));
    end

    assign o_level_out = r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_x   <= i_x_pos;
            r_y   <= i_y_pos;
            r_run <= i_run_length;
            r_lvl <= i_level;
        end
        if (i_cmd.check) begin
            r_col   <= EW'(x_clip_s);
            r_count <= EW'(cnt_s);
            r_base  <= AW'(prod);
            r_wlvl  <= lvl_clamp;
        end else if (i_cmd.fill) begin
            r_count <= r_count - EW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.check) begin
            r_addr <= '0;
        end else if (i_cmd.addr) begin
            r_addr <= r_base + AW'(r_col);
        end else if (i_cmd.fill || i_cmd.sweep) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill || i_cmd.sweep) begin
            r_store[r_addr] <= i_cmd.fill ? r_wlvl : FULL_U;
        end
        if (i_cmd.rd) begin
            r_result <= r_store[r_addr];
        end else if (i_cmd.check) begin
            r_result <= FULL_U;
        end
    end

endmodule

>>> design/clipped_span_fill_level_map.sv
// Channel   Handshake                        Payload
// -------   ------------------------------   ----------------------------------------------
// item in   start / busy (transfer when       i_opcode, i_x_pos, i_y_pos, i_run_length,
//           start high and busy low)         i_level
// result    o_done, one cycle, no backpress  o_level_out
// config    APB psel/penable/pwrite/pready   paddr, pwdata, prdata (width at 0, height at 4)
//
// Read: check, address and read steps. Fill: check and address steps, then one store write
// per cycle per run cell. Clear: a check step, then a sweep of the store one cell per cycle.
// Rejected fill/read or unused opcode: check only. The next item is taken in the result cycle.
// After reset busy stays high while all MAX_WIDTH*MAX_HEIGHT store cells are swept
// to full light; configuration writes are taken throughout.
// The result is shown for one cycle only; the receiver cannot stall it.
module clipped_span_fill_level_map #(
    parameter int MAX_WIDTH  = csfl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csfl_pkg::MAX_HEIGHT_DEF,
    parameter int FULL_LIGHT = csfl_pkg::FULL_LIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [csfl_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_x_pos,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_y_pos,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_run_length,
    input  logic signed [csfl_pkg::COORD_W-1:0] i_level,
    output logic                                o_done,
    output logic [csfl_pkg::LEVEL_W-1:0]        o_level_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int RW = csfl_pkg::REG_W;

    logic [RW-1:0]      r_map_width;
    logic [RW-1:0]      r_map_height;
    logic               cfg_wr;
    csfl_pkg::t_dp_cmd  cmd;
    csfl_pkg::t_dp_stat stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == csfl_pkg::REG_HEIGHT) ? 32'(r_map_height) : 32'(r_map_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= '0;
            r_map_height <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == csfl_pkg::REG_WIDTH) begin
                r_map_width <= pwdata[RW-1:0];
            end else begin
                r_map_height <= pwdata[RW-1:0];
            end
        end
    end

    csfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    csfl_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FULL_LIGHT (FULL_LIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .i_opcode     (i_opcode),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_run_length (i_run_length),
        .i_level      (i_level),
        .o_level_out  (o_level_out)
    );

endmodule

>>> design/csfl_checker.sv
module csfl_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // a result only ends a job that was in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a job in progress");

    // an accepted item makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // one result per job: the strobe is never held high
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // no result in the cycle right after a transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result appeared the cycle after a transfer");

endmodule

bind clipped_span_fill_level_map csfl_checker u_csfl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
